// File: hdl/afrd_pkg.sv
// afrd_pkg: shared types and constants for the api frame receive deframer
// no dependencies; used by the interfaces, core and top level

package afrd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;

  localparam logic [ByteW-1:0] DelimByte    = 8'h7E;
  localparam logic [ByteW-1:0] RxTypeByte   = 8'h90;
  localparam logic [LenW-1:0]  PayloadStart = 16'd12;

  // frame parser phase
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_BODY   = 3'd3,
    PH_CSUM   = 3'd4
  } phase_t;

  // one result beat out of the core
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

endpackage

// File: hdl/afrd_in_if.sv
// afrd_in_if: valid/ready channel carrying one received serial byte per beat
// depends on afrd_pkg

interface afrd_in_if;
  logic                       valid;
  logic                       ready;
  logic [afrd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/afrd_out_if.sv
// afrd_out_if: valid/ready channel carrying one payload byte per beat
// depends on afrd_pkg

interface afrd_out_if;
  logic                       valid;
  logic                       ready;
  logic [afrd_pkg::ByteW-1:0] payload_byte;
  logic                       payload_last;

  modport source (output valid, output payload_byte, output payload_last, input ready);
  modport sink   (input valid, input payload_byte, input payload_last, output ready);
endinterface

// File: hdl/afrd_core.sv
// afrd_core: frame phase machine, length/count registers and one-byte payload hold
// depends on afrd_pkg; steps once per byte when step_en is high

module afrd_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [afrd_pkg::ByteW-1:0] byte_in,
  output afrd_pkg::result_t          result
);

  afrd_pkg::phase_t             phase_r, phase_nxt;
  logic [afrd_pkg::LenW-1:0]    len_r, len_nxt;
  logic [afrd_pkg::LenW-1:0]    count_r, count_nxt;
  logic                         accepted_r, accepted_nxt;
  logic [afrd_pkg::ByteW-1:0]   held_r, held_nxt;
  logic                         held_valid_r, held_valid_nxt;

  logic                         acc_now;
  logic [afrd_pkg::LenW-1:0]    count_inc;

  assign count_inc = count_r + afrd_pkg::LenW'(1);

  // type check happens on the first body byte
  assign acc_now = (count_r == '0)
                 ? ((byte_in == afrd_pkg::RxTypeByte) && (len_r > afrd_pkg::PayloadStart))
                 : accepted_r;

  // next state and result for one byte
  always_comb begin
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    accepted_nxt   = accepted_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    result         = '0;
    case (phase_r)
      afrd_pkg::PH_LEN_HI: begin
        len_nxt   = {byte_in, {afrd_pkg::ByteW{1'b0}}};
        phase_nxt = afrd_pkg::PH_LEN_LO;
      end
      afrd_pkg::PH_LEN_LO: begin
        len_nxt        = {len_r[afrd_pkg::LenW-1:afrd_pkg::ByteW], byte_in};
        count_nxt      = '0;
        accepted_nxt   = 1'b0;
        held_valid_nxt = 1'b0;
        phase_nxt      = ({len_r[afrd_pkg::LenW-1:afrd_pkg::ByteW], byte_in} == '0)
                       ? afrd_pkg::PH_CSUM : afrd_pkg::PH_BODY;
      end
      afrd_pkg::PH_BODY: begin
        accepted_nxt = acc_now;
        if (acc_now && (count_r >= afrd_pkg::PayloadStart)) begin
          result.valid   = held_valid_r;
          result.data    = held_r;
          result.last    = 1'b0;
          held_nxt       = byte_in;
          held_valid_nxt = 1'b1;
        end
        count_nxt = count_inc;
        if (count_inc == len_r) begin
          phase_nxt = afrd_pkg::PH_CSUM;
        end
      end
      afrd_pkg::PH_CSUM: begin
        result.valid   = held_valid_r;
        result.data    = held_r;
        result.last    = 1'b1;
        held_valid_nxt = 1'b0;
        accepted_nxt   = 1'b0;
        phase_nxt      = afrd_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = (byte_in == afrd_pkg::DelimByte) ? afrd_pkg::PH_LEN_HI
                                                     : afrd_pkg::PH_HUNT;
      end
    endcase
    if (!step_en) begin
      result.valid = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= afrd_pkg::PH_HUNT;
      len_r        <= '0;
      count_r      <= '0;
      accepted_r   <= 1'b0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      len_r        <= len_nxt;
      count_r      <= count_nxt;
      accepted_r   <= accepted_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

// File: hdl/api_frame_receive_deframer_unit.sv
// path: taken byte -> input register -> core logic -> output register
// throughput: one byte per cycle; the input register advances whenever the output
// register is empty or its beat is taken in the same cycle
// reset: synchronous active-low rst_n clears both registers' valid bits and the
// parser state (hunting for the delimiter, counters and held byte cleared)
// depends on afrd_pkg, afrd_in_if, afrd_out_if and afrd_core

module api_frame_receive_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  afrd_in_if.sink     in_bus,
  afrd_out_if.source  out_bus
);

  logic                        in_valid_r;
  logic [afrd_pkg::ByteW-1:0]  in_byte_r;
  logic                        out_valid_r;
  logic [afrd_pkg::ByteW-1:0]  out_byte_r;
  logic                        out_last_r;
  logic                        advance;
  logic                        step_en;
  afrd_pkg::result_t           core_res;

  // input stage moves on when the output register can take its result
  assign advance      = !out_valid_r || out_bus.ready;
  assign step_en      = in_valid_r && advance;
  assign in_bus.ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_byte_r <= in_bus.rx_byte;
    end
  end

  afrd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (in_byte_r),
    .result  (core_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res.valid) begin
      out_byte_r <= core_res.data;
      out_last_r <= core_res.last;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.payload_byte = out_byte_r;
  assign out_bus.payload_last = out_last_r;

endmodule

// File: hdl/afrd_checker.sv
// afrd_checker: port-level checks for the deframer top level, attached by bind
// depends on afrd_pkg and api_frame_receive_deframer_unit

module afrd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [afrd_pkg::ByteW-1:0] out_payload_byte,
  input logic                       out_payload_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
                                && $stable(out_payload_last))
    else $error("result beat changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a new result beat comes from an input byte that was taken earlier
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(rst_n) && $past(rst_n, 2) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without an input byte");

endmodule

bind api_frame_receive_deframer_unit afrd_checker u_afrd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_bus.valid),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_payload_byte (out_bus.payload_byte),
  .out_payload_last (out_bus.payload_last)
);
